// ===== rtl/evbar_pkg.sv =====
// Shared types and constants for the event barrier block.
package evbar_pkg;

  // Field widths of one event.
  localparam int TYPE_W  = 16;
  localparam int CODE_W  = 16;
  localparam int VALUE_W = 32;
  localparam int SEC_W   = 32;
  localparam int USEC_W  = 20;
  localparam int EV_W    = TYPE_W + CODE_W + VALUE_W + SEC_W + USEC_W;
  localparam int TDATA_W = ((EV_W + 7) / 8) * 8;
  localparam int PAD_W   = TDATA_W - EV_W;

  // Configuration register.
  localparam int CAP_W = 6;
  localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

  // Default store depth.
  localparam int QUEUE_DEPTH_DEF = 32;

  // Sync report: type 0 and code 0.
  localparam logic [TYPE_W-1:0] SYNC_TYPE = '0;
  localparam logic [CODE_W-1:0] SYNC_CODE = '0;

  // One event; the first member lands in the top bits, so type sits lowest,
  // matching the tdata layout.
  typedef struct packed {
    logic [USEC_W-1:0]         time_usec;
    logic [SEC_W-1:0]          time_sec;
    logic signed [VALUE_W-1:0] ev_value;
    logic [CODE_W-1:0]         ev_code;
    logic [TYPE_W-1:0]         ev_type;
  } ev_fields_t;

  // One classified request in the queue between front and back.
  typedef struct packed {
    logic       is_sync;
    ev_fields_t fields;
  } ev_item_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FLUSH,
    BK_SYNC
  } back_state_t;

  // Status of the front queue.
  typedef struct packed {
    logic head_valid;
    logic full;
  } fr_status_t;

  // Status of the back end.
  typedef struct packed {
    back_state_t state;
    logic        rd_pend;
    logic        empty;
  } bk_status_t;

endpackage

// ===== rtl/evbar_front.sv =====
// Front end: accepts events, flags sync reports and queues them for the back end.
module evbar_front
  import evbar_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,
  input  logic               pop,
  output ev_item_t           head,
  output fr_status_t         status
);

  ev_item_t   q_item_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  ev_item_t   in_item;
  logic       do_pop;

  // Classify the incoming request.
  always_comb begin
    in_item.fields  = ev_fields_t'(in_tdata[EV_W-1:0]);
    in_item.is_sync = (in_item.fields.ev_type == SYNC_TYPE) &&
                      (in_item.fields.ev_code == SYNC_CODE);
  end

  assign in_tready = (count_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign do_pop    = pop && (count_r != 2'd0);

  // Pointer and occupancy update of the two-entry queue.
  always_comb begin
    wr_ptr_nxt = push   ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue payload needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      q_item_r[wr_ptr_r] <= in_item;
    end
  end

  assign head              = q_item_r[rd_ptr_r];
  assign status.head_valid = (count_r != 2'd0);
  assign status.full       = (count_r == 2'd2);

endmodule

// ===== rtl/evbar_back.sv =====
// Back end: stores held events and releases them, then the sync event, on a sync report.
module evbar_back
  import evbar_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wen,
  input  logic [CAP_W-1:0]   cfg_wdata,
  input  ev_item_t           head,
  input  fr_status_t         q_status,
  output logic               pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,
  output logic               out_tlast,
  output bk_status_t         status
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int CW = CAP_W + 1;
  localparam logic [FW-1:0] DEPTH_F = FW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [FW-1:0] ONE_F   = FW'(1);

  logic [EV_W-1:0]  mem [QUEUE_DEPTH];
  logic [CAP_W-1:0] cap_r;
  logic [FW-1:0]    cap_eff;
  back_state_t      state_r, state_nxt;
  logic [FW-1:0]    fill_r, fill_nxt;
  logic [FW-1:0]    rd_idx_r, rd_idx_nxt;
  logic [FW-1:0]    rd_idx_inc;
  logic             rd_pend_r;
  logic [EV_W-1:0]  rd_data_r;
  logic             out_valid_r;
  logic [EV_W-1:0]  out_data_r;
  logic             out_last_r;
  logic             slot_free;
  logic             mem_we;
  logic             rd_issue;
  logic             sync_load;

  // Capacity register, saturated at the store depth.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wen) begin
      cap_r <= cfg_wdata;
    end
  end

  assign cap_eff    = (CW'(cap_r) > DEPTH_C) ? DEPTH_F : FW'(cap_r);
  assign slot_free  = !out_valid_r || out_tready;
  assign rd_idx_inc = rd_idx_r + ONE_F;

  // Sequencer: hold, flush held events, then close with the sync event.
  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    rd_idx_nxt = rd_idx_r;
    pop        = 1'b0;
    mem_we     = 1'b0;
    rd_issue   = 1'b0;
    sync_load  = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (q_status.head_valid) begin
          if (!head.is_sync) begin
            pop = 1'b1;
            if (fill_r < cap_eff) begin
              mem_we   = 1'b1;
              fill_nxt = fill_r + ONE_F;
            end
          end else if (fill_r == '0) begin
            state_nxt = BK_SYNC;
          end else begin
            state_nxt  = BK_FLUSH;
            rd_idx_nxt = '0;
          end
        end
      end
      BK_FLUSH: begin
        if (!rd_pend_r && slot_free) begin
          rd_issue   = 1'b1;
          rd_idx_nxt = rd_idx_inc;
          if (rd_idx_inc == fill_r) begin
            state_nxt = BK_SYNC;
          end
        end
      end
      BK_SYNC: begin
        if (!rd_pend_r && slot_free) begin
          sync_load = 1'b1;
          pop       = 1'b1;
          fill_nxt  = '0;
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      fill_r    <= '0;
      rd_idx_r  <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      rd_idx_r  <= rd_idx_nxt;
      rd_pend_r <= rd_issue;
    end
  end

  // Event store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[fill_r[AW-1:0]] <= EV_W'(head.fields);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_issue) begin
      rd_data_r <= mem[rd_idx_r[AW-1:0]];
    end
  end

  // Output register, loaded from the store or from the queued sync event.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rd_pend_r || sync_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend_r) begin
      out_data_r <= rd_data_r;
      out_last_r <= 1'b0;
    end else if (sync_load) begin
      out_data_r <= EV_W'(head.fields);
      out_last_r <= 1'b1;
    end
  end

  assign out_tvalid     = out_valid_r;
  assign out_tdata      = {{PAD_W{1'b0}}, out_data_r};
  assign out_tlast      = out_last_r;
  assign status.state   = state_r;
  assign status.rd_pend = rd_pend_r;
  assign status.empty   = (fill_r == '0);

endmodule

// ===== rtl/event_barrier_until_sync_core.sv =====
// Top level of the event barrier: holds events until a sync report releases them.
//
// Events enter on the in_ stream and are held in an on-chip store of QUEUE_DEPTH
// entries until a sync report (type 0, code 0) arrives. The sync report releases
// all held events in arrival order on the out_ stream, then itself with tlast set.
// A non-sync event that meets a full store (capacity from cfg_wdata, saturated
// at QUEUE_DEPTH) is dropped. A held event is written through the front queue and
// the store's single write port. During a release each result passes through the
// store's registered read port into the output register, and the next store read
// is issued only once the previous one has been loaded. A two-entry queue lets new
// events enter while a release is running.
module event_barrier_until_sync_core
  import evbar_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wen,
  input  logic [CAP_W-1:0]   cfg_wdata,
  input  logic               in_tvalid,
  output logic               in_tready,
  // Low to high: ev_type, ev_code, ev_value, time_sec, time_usec, zero pad.
  input  logic [TDATA_W-1:0] in_tdata,
  output logic               out_tvalid,
  input  logic               out_tready,
  // Low to high: out_type, out_code, out_value, out_sec, out_usec, zero pad.
  output logic [TDATA_W-1:0] out_tdata,
  output logic               out_tlast
);

  ev_item_t   head;
  fr_status_t fr_status;
  bk_status_t bk_status;
  logic       pop;

  evbar_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .pop       (pop),
    .head      (head),
    .status    (fr_status)
  );

  evbar_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .head       (head),
    .q_status   (fr_status),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .status     (bk_status)
  );

  // After an accepted request the queue head is valid on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> fr_status.head_valid)
    else $error("accepted request missing from queue");

  // A flush only runs while events are held in the store.
  assert property (@(posedge clk) disable iff (!rst_n)
    bk_status.state == BK_FLUSH |-> !bk_status.empty)
    else $error("flush running on an empty store");

  // Store reads happen only during a release.
  assert property (@(posedge clk) disable iff (!rst_n)
    bk_status.rd_pend |-> bk_status.state != BK_IDLE)
    else $error("store read outside a release");

  // The back end never pops while the queue is full and a flush is running.
  assert property (@(posedge clk) disable iff (!rst_n)
    fr_status.full && bk_status.state == BK_FLUSH |-> !pop)
    else $error("queue popped during flush");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the event barrier core: a directed table, then random sync groups.
module tb;
  import evbar_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_GAP    = 12;
  localparam int LONG_HOLD    = 300;
  localparam int RAND_ITEMS   = 40;

  // One released request as it should appear on the output stream.
  typedef struct packed {
    ev_fields_t ev;
    logic       last;
  } flush_ev_t;

  typedef enum logic {ROW_EVENT, ROW_CAP} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [CAP_W-1:0]  cap;
    ev_fields_t        ev;
    bit                fixed;
    flush_ev_t         want;
  } stim_row_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_wen;
  logic [CAP_W-1:0]   cfg_wdata;
  logic               in_tvalid;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata;
  logic               out_tvalid;
  logic               out_tready;
  logic [TDATA_W-1:0] out_tdata;
  logic               out_tlast;

  // Shadow copy of the store, the fill level and the capacity register.
  ev_fields_t       held_ev [QUEUE_DEPTH_DEF];
  int unsigned      held_cnt;
  logic [CAP_W-1:0] cap_reg;
  flush_ev_t        pending_q[$];

  stim_row_t        dir_rows[$];
  logic [CAP_W-1:0] cap_pick [8] = '{6'd63, 6'd32, 6'd33, 6'd31, 6'd0, 6'd1, 6'd3, 6'd2};

  int  fail_cnt;
  int  cycles;
  int  events_in;
  int  effective_items;
  int  results_seen;
  int  cap_writes;
  int  longest_flush;
  int  idle_pct;
  bit  calm;
  bit  hold_req;

  flush_ev_t  mon_want;
  ev_fields_t mon_got;

  event_barrier_until_sync_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic ev_fields_t make_ev(input logic [TYPE_W-1:0] t, input logic [CODE_W-1:0] c,
                                         input logic [VALUE_W-1:0] v, input logic [SEC_W-1:0] s,
                                         input logic [USEC_W-1:0] u);
    ev_fields_t e;
    e.ev_type   = t;
    e.ev_code   = c;
    e.ev_value  = v;
    e.time_sec  = s;
    e.time_usec = u;
    return e;
  endfunction

  // Barrier predictor: a sync report flushes the store and itself, anything else is held
  // if there is room. Returns 1 when the request had an effect.
  function automatic bit barrier_step(input ev_fields_t ev, input bit record);
    int unsigned eff_cap;
    int unsigned i;
    eff_cap = (cap_reg > QUEUE_DEPTH_DEF) ? QUEUE_DEPTH_DEF : int'(cap_reg);
    if (ev.ev_type == SYNC_TYPE && ev.ev_code == SYNC_CODE) begin
      if (record) begin
        for (i = 0; i < held_cnt; i++) pending_q.push_back({held_ev[i], 1'b0});
        pending_q.push_back({ev, 1'b1});
      end
      if (held_cnt + 1 > longest_flush) longest_flush = held_cnt + 1;
      held_cnt = 0;
      return 1'b1;
    end
    if (held_cnt < eff_cap) begin
      held_ev[held_cnt] = ev;
      held_cnt++;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Random non-sync request, with the occasional corner value mixed in.
  function automatic ev_fields_t rand_held();
    ev_fields_t e;
    e = make_ev(16'($urandom), 16'($urandom), $urandom, $urandom,
                20'($urandom_range(0, 999999)));
    case ($urandom_range(0, 9))
      0: e.ev_type = SYNC_TYPE;
      1: e.time_usec = 20'($urandom);
      2: e.ev_value = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      3: begin
        e.time_sec  = 32'hFFFF_FFFF;
        e.time_usec = '0;
      end
      default: ;
    endcase
    // Keep it out of the sync report encoding.
    if (e.ev_type == SYNC_TYPE && e.ev_code == SYNC_CODE) e.ev_code = 16'd1;
    return e;
  endfunction

  function automatic stim_row_t ev_row(input ev_fields_t ev);
    stim_row_t r;
    r.kind  = ROW_EVENT;
    r.cap   = '0;
    r.ev    = ev;
    r.fixed = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  function automatic stim_row_t cap_row(input logic [CAP_W-1:0] v);
    stim_row_t r;
    r = ev_row('0);
    r.kind = ROW_CAP;
    r.cap  = v;
    return r;
  endfunction

  function automatic stim_row_t fixed_row(input ev_fields_t ev, input flush_ev_t want);
    stim_row_t r;
    r = ev_row(ev);
    r.fixed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      fail_cnt++;
      $error("%s: expected %h, got %h", name, want, got);
    end
  endtask

  // Stop offering, wait for every pending result, then give the front end time to settle.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    wait_idle();
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cap_reg = v;
    cap_writes++;
    cfg_wen <= 1'b0;
  endtask

  // Offer one request, wait for the handshake, predict, then maybe idle for a short burst.
  task automatic send_event(input ev_fields_t ev, input bit fixed, input flush_ev_t want);
    in_tdata  <= {{PAD_W{1'b0}}, ev};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    effective_items += barrier_step(ev, !fixed);
    if (fixed) pending_q.push_back(want);
    events_in++;
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // A group of held requests closed by a sync report.
  task automatic send_group(input int n);
    int i;
    for (i = 0; i < n; i++) send_event(rand_held(), 1'b0, '0);
    send_event(make_ev(SYNC_TYPE, SYNC_CODE, $urandom, $urandom,
                       20'(($urandom_range(0, 7) == 0) ? $urandom
                                                       : $urandom_range(0, 999999))),
               1'b0, '0);
  endtask

  // Result checker: every accepted result must match the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_q.size() == 0) begin
        fail_cnt++;
        $error("unexpected result: tdata %h, tlast %b", out_tdata, out_tlast);
      end else begin
        mon_want = pending_q.pop_front();
        mon_got  = out_tdata[EV_W-1:0];
        check_field("out_type", 32'(mon_want.ev.ev_type), 32'(mon_got.ev_type));
        check_field("out_code", 32'(mon_want.ev.ev_code), 32'(mon_got.ev_code));
        check_field("out_value", mon_want.ev.ev_value, mon_got.ev_value);
        check_field("out_sec", mon_want.ev.time_sec, mon_got.time_sec);
        check_field("out_usec", 32'(mon_want.ev.time_usec), 32'(mon_got.time_usec));
        check_field("last_of_group", 32'(mon_want.last), 32'(out_tlast));
        check_field("tdata_pad", '0, 32'(out_tdata[TDATA_W-1:EV_W]));
        results_seen++;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("[event_barrier_until_sync_core] ERROR");
      $finish;
    end
  end

  // Receiver: random short stalls, one long hold-off on request, none at the end.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_tready <= 1'b1;
      end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Main sequence.
  initial begin
    int phase;
    int start_items;
    int k;
    clk       = 1'b0;
    rst_n     = 1'b0;
    cfg_wen   = 1'b0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    fail_cnt  = 0;
    cycles    = 0;
    events_in = 0;
    effective_items = 0;
    results_seen    = 0;
    cap_writes      = 0;
    longest_flush   = 0;
    idle_pct  = 20;
    calm      = 1'b0;
    hold_req  = 1'b0;
    held_cnt  = 0;
    cap_reg   = CAP_RESET;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table.
    // Sync reports on an empty store come straight back with tlast set.
    dir_rows.push_back(fixed_row(make_ev(16'h0, 16'h0, 32'h0, 32'h0, 20'h0),
                                 {make_ev(16'h0, 16'h0, 32'h0, 32'h0, 20'h0), 1'b1}));
    dir_rows.push_back(fixed_row(make_ev(16'h0, 16'h0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 20'hFFFFF),
                                 {make_ev(16'h0, 16'h0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 20'hFFFFF),
                                  1'b1}));
    // Extremes, a sync type with nonzero code, and a nonzero type with code zero are held.
    dir_rows.push_back(ev_row(make_ev(16'hFFFF, 16'hFFFF, 32'h8000_0000, 32'h0, 20'h0)));
    dir_rows.push_back(ev_row(make_ev(16'h0, 16'h1, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 20'hFFFFF)));
    dir_rows.push_back(ev_row(make_ev(16'h1, 16'h0, 32'hFFFF_FFFF, 32'h1234_5678, 20'd999999)));
    dir_rows.push_back(ev_row(make_ev(16'h0, 16'h0, 32'd5, 32'd100, 20'd7)));
    // Capacity zero: everything dropped, the sync releases only itself.
    dir_rows.push_back(cap_row(6'd0));
    dir_rows.push_back(ev_row(make_ev(16'h00AA, 16'h0055, 32'h5555_AAAA, 32'hAAAA_5555, 20'h5A5A5)));
    dir_rows.push_back(fixed_row(make_ev(16'h0, 16'h0, 32'h1234, 32'd10, 20'd20),
                                 {make_ev(16'h0, 16'h0, 32'h1234, 32'd10, 20'd20), 1'b1}));
    // Small capacity: the third request overflows and is dropped.
    dir_rows.push_back(cap_row(6'd2));
    dir_rows.push_back(ev_row(make_ev(16'h3, 16'h1, 32'd1, 32'd1, 20'd1)));
    dir_rows.push_back(ev_row(make_ev(16'h3, 16'h2, 32'd2, 32'd2, 20'd2)));
    dir_rows.push_back(ev_row(make_ev(16'h3, 16'h3, 32'd3, 32'd3, 20'd3)));
    dir_rows.push_back(ev_row(make_ev(16'h0, 16'h0, 32'd4, 32'd4, 20'd4)));
    // Capacity lowered below the fill level: held requests survive, new ones drop.
    dir_rows.push_back(cap_row(6'd32));
    dir_rows.push_back(ev_row(make_ev(16'h1, 16'h10, 32'hDEAD_BEEF, 32'd11, 20'd11)));
    dir_rows.push_back(ev_row(make_ev(16'h2, 16'h20, 32'hCAFE_F00D, 32'd12, 20'd12)));
    dir_rows.push_back(ev_row(make_ev(16'h3, 16'h30, 32'h0BAD_CAFE, 32'd13, 20'd13)));
    dir_rows.push_back(cap_row(6'd1));
    dir_rows.push_back(ev_row(make_ev(16'h4, 16'h40, 32'h1, 32'd14, 20'd14)));
    dir_rows.push_back(ev_row(make_ev(16'h0, 16'h0, 32'h2, 32'd15, 20'd15)));

    foreach (dir_rows[k]) begin
      if (dir_rows[k].kind == ROW_CAP) begin
        write_capacity(dir_rows[k].cap);
      end else begin
        send_event(dir_rows[k].ev, dir_rows[k].fixed, dir_rows[k].want);
      end
    end

    // Capacity above the store depth saturates; a full store flushes the most results.
    write_capacity(6'd63);
    send_group(33);

    // Long receiver hold-off while the sender keeps pushing sync groups.
    wait_idle();
    hold_req = 1'b1;
    for (k = 0; k < 3; k++) send_group(3);
    wait_idle();

    // Random phases: a capacity setting, then a few groups, sometimes left partly held.
    start_items = events_in;
    phase = 0;
    while (events_in < start_items + RAND_ITEMS) begin
      idle_pct = (phase % 3 == 0) ? 0 : $urandom_range(10, 40);
      write_capacity((phase < 8) ? cap_pick[phase] : 6'($urandom_range(0, 63)));
      repeat ($urandom_range(1, 4)) begin
        send_group(($urandom_range(0, 9) == 0) ? $urandom_range(8, 36) : $urandom_range(0, 5));
      end
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 4)) send_event(rand_held(), 1'b0, '0);
      end
      phase++;
    end

    // Closing stretch without any idling.
    calm = 1'b1;
    write_capacity(6'd32);
    send_group(5);
    send_group(0);
    send_group(8);
    wait_idle();

    $display("Covered %0d requests (%0d held or released) and %0d checked results over %0d capacity writes.",
             events_in, effective_items, results_seen, cap_writes);
    $display("Longest flush was %0d results; run took %0d cycles.", longest_flush, cycles);
    if (fail_cnt == 0) begin
      $display("[event_barrier_until_sync_core] OK");
    end else begin
      $display("[event_barrier_until_sync_core] ERROR");
    end
    $finish;
  end

endmodule
